### hw/rtl/ppw_pkg.sv
package ppw_pkg;

	localparam int POS_W      = 32;
	localparam int PW_W       = 16;
	localparam int QUO_W      = 16;
	localparam int PROD_W     = POS_W + QUO_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// three front stages, one per quotient bit, width stage, output stage
	localparam int LATENCY = QUO_W + 5;

	localparam logic [PW_W-1:0]         PULSE_LIMIT   = 16'd50000;
	localparam logic [PW_W-1:0]         RST_MAX_PULSE = 16'd2500;
	localparam logic [PW_W-1:0]         RST_MIN_PULSE = 16'd500;
	localparam logic signed [POS_W-1:0] RST_MAX_POS   = 32'sd1422;
	localparam logic signed [POS_W-1:0] RST_MIN_POS   = -32'sd1422;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PULSE,
		REG_MIN_PULSE,
		REG_MAX_POS,
		REG_MIN_POS
	} cfg_reg_t;

	typedef struct packed {
		logic            op;
		logic [PW_W-1:0] raw;
	} ppw_tag_t;

	function automatic logic [PW_W-1:0] limit_pulse(input logic [PW_W-1:0] w);
		return (w > PULSE_LIMIT) ? PULSE_LIMIT : w;
	endfunction

endpackage

### hw/rtl/ppw_div.sv
module ppw_div
	import ppw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [PROD_W-1:0] num,
	input  logic [POS_W-1:0]  den,
	input  ppw_tag_t          in_tag,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output ppw_tag_t          out_tag
);

	// Restoring division, one quotient bit per stage. The caller keeps
	// num below den * 2**QUO_W, so the partial remainder fits POS_W bits.
	logic             vld_s [1:QUO_W];
	logic [POS_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] lq_s  [1:QUO_W];
	ppw_tag_t         tag_s [1:QUO_W];

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic             src_vld;
		logic [POS_W-1:0] src_rem;
		logic [QUO_W-1:0] src_lq;
		ppw_tag_t         src_tag;
		logic [POS_W:0]   cand;
		logic             fits;

		if (k == 1) begin : g_src
			assign src_vld = in_valid;
			assign src_rem = num[PROD_W-1:QUO_W];
			assign src_lq  = num[QUO_W-1:0];
			assign src_tag = in_tag;
		end else begin : g_src
			assign src_vld = vld_s[k-1];
			assign src_rem = rem_s[k-1];
			assign src_lq  = lq_s[k-1];
			assign src_tag = tag_s[k-1];
		end

		// low dividend bits shift out the top while quotient bits enter below
		assign cand = {src_rem, src_lq[QUO_W-1]};
		assign fits = cand >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= fits ? POS_W'(cand - {1'b0, den}) : cand[POS_W-1:0];
			lq_s[k]  <= {src_lq[QUO_W-2:0], fits};
			tag_s[k] <= src_tag;
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo       = lq_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];

endmodule

### hw/rtl/position_to_pulse_width_mapper.sv
// Maps a target position (operation 0) or passes a raw pulse width (operation 1) to a
// timer compare value. The block takes one item every cycle and busy stays low; each
// result appears on compare_value and range_error for one cycle with done high, in
// start order. The receiver cannot stall, so it must capture each result in its done
// cycle. Each item passes through clamp, offset and multiply stages, then the 16-stage
// divider that resolves one quotient bit per stage, then width and output stages.
// Write the range registers only while no item is in flight.
module position_to_pulse_width_mapper
	import ppw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    operation,
	input  logic signed [POS_W-1:0] target_position,
	input  logic [PW_W-1:0]         raw_pulse,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    done,
	output logic [PW_W-1:0]         compare_value,
	output logic                    range_error
);

	logic [PW_W-1:0]         max_pulse_q;
	logic [PW_W-1:0]         min_pulse_q;
	logic signed [POS_W-1:0] max_position_q;
	logic signed [POS_W-1:0] min_position_q;

	logic [PW_W-1:0]  wmax;
	logic [PW_W-1:0]  wmin;
	logic [PW_W-1:0]  dw;
	logic [POS_W-1:0] den;
	logic             range_bad;

	logic                    vld_s1;
	logic signed [POS_W-1:0] pos_s1;
	ppw_tag_t                tag_s1;
	logic                    vld_s2;
	logic [POS_W-1:0]        diff_s2;
	ppw_tag_t                tag_s2;
	logic                    vld_s3;
	logic [PROD_W-1:0]       prod_s3;
	ppw_tag_t                tag_s3;

	logic             div_vld;
	logic [QUO_W-1:0] div_quo;
	ppw_tag_t         div_tag;

	logic            vld_s4;
	logic [PW_W:0]   width_s4;
	logic [PW_W:0]   width_clamped;
	logic [PW_W-1:0] cmp_next;

	logic            done_q;
	logic [PW_W-1:0] compare_q;
	logic            error_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pulse_q    <= RST_MAX_PULSE;
			min_pulse_q    <= RST_MIN_PULSE;
			max_position_q <= RST_MAX_POS;
			min_position_q <= RST_MIN_POS;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_PULSE: max_pulse_q    <= cfg_data[PW_W-1:0];
				REG_MIN_PULSE: min_pulse_q    <= cfg_data[PW_W-1:0];
				REG_MAX_POS:   max_position_q <= cfg_data[POS_W-1:0];
				REG_MIN_POS:   min_position_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Users must change range values only when idle (unchecked); all stages read them.
	assign wmax      = limit_pulse(max_pulse_q);
	assign wmin      = limit_pulse(min_pulse_q);
	assign dw        = wmax - wmin;
	assign den       = POS_W'(max_position_q - min_position_q);
	assign range_bad = (wmax <= wmin) || (max_position_q <= min_position_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= div_vld;
			done_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// clamp to the position range
		if (target_position > max_position_q) begin
			pos_s1 <= max_position_q;
		end else if (target_position < min_position_q) begin
			pos_s1 <= min_position_q;
		end else begin
			pos_s1 <= target_position;
		end
		tag_s1  <= '{op: operation, raw: raw_pulse};

		diff_s2 <= POS_W'(pos_s1 - min_position_q);
		tag_s2  <= tag_s1;

		prod_s3 <= PROD_W'(diff_s2) * PROD_W'(dw);
		tag_s3  <= tag_s2;

		width_s4 <= div_tag.op ? {1'b0, div_tag.raw}
		                       : {1'b0, wmin} + {1'b0, div_quo};

		compare_q <= range_bad ? '0 : cmp_next;
		error_q   <= range_bad;
	end

	ppw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.num       (prod_s3),
		.den       (den),
		.in_tag    (tag_s3),
		.out_valid (div_vld),
		.quo       (div_quo),
		.out_tag   (div_tag)
	);

	always_comb begin
		if (width_s4 > {1'b0, wmax}) begin
			width_clamped = {1'b0, wmax};
		end else if (width_s4 < {1'b0, wmin}) begin
			width_clamped = {1'b0, wmin};
		end else begin
			width_clamped = width_s4;
		end
		// saturate at zero instead of wrapping
		if (width_clamped == '0) begin
			cmp_next = '0;
		end else begin
			cmp_next = PW_W'(width_clamped - 1'b1);
		end
	end

	assign done          = done_q;
	assign compare_value = compare_q;
	assign range_error   = error_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result beat missing after fixed latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat without a matching start");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_error |-> compare_value == '0)
		else $error("range error with nonzero compare value");

	a_cmp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && !range_error |-> compare_value < PULSE_LIMIT)
		else $error("compare value beyond pulse limit");

endmodule
